[sv/lcsf_pkg.sv]
package lcsf_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned StepWidth = 7;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 10;

   localparam logic [CsrIdxWidth-1:0] CSR_LED_LEVEL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SAT_GAIN = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SMOOTH_EN = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SIM_THRESH = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_FADE_EN = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_FADE_STEPS = 3'd5;

   localparam logic [15:0] LumaWr = 16'd19595;
   localparam logic [15:0] LumaWg = 16'd38470;
   localparam logic [15:0] LumaWb = 16'd7471;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } color_type;

   // one accepted job: target colour and step count
   typedef struct packed {
      color_type  color;
      logic [6:0] steps;
   } job_type;

   typedef enum logic [2:0] {
      ADJ_IDLE,
      ADJ_SCALE,
      ADJ_LUMA,
      ADJ_BOOST,
      ADJ_ROUND,
      ADJ_PUSH
   } adj_state_type;

   typedef enum logic [2:0] {
      FD_IDLE,
      FD_MUL,
      FD_DIV,
      FD_FIN,
      FD_OUT
   } fade_state_type;

   // larger-minus-smaller absolute difference of two channels
   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? a - b : b - a;
      return d;
   endfunction

endpackage

[sv/led_color_smoother_fader.sv]
// Colour adjuster and fader for an LED driver. Each screen colour taken on
// req_ is scaled by led_level, saturation-boosted around its luma, and run
// through a three-deep similarity check; an accepted colour produces
// fade_steps interpolated results on rsp_ (capped at MAX_FADE_STEPS; one when
// fading is off or fade_steps is zero), a rejected one produces none. The
// front end scales, weighs luma, and boosts and rounds the three channels in
// turn, then pushes an accepted job, waiting there while the job queue is full;
// it takes no new colour until it is back in idle. For each step the fade
// engine multiplies and divides each channel with a bit-serial divider, then
// holds the result on rsp_ until it is taken. A two-entry job queue lets the
// front take the next colour while a fade is running. Write csr_ only while idle.
module led_color_smoother_fader #(
   parameter int unsigned MAX_FADE_STEPS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic       rsp_changed,
   output logic       rsp_last_step,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_data
);

   logic [7:0] led_level_ff;
   logic [9:0] sat_gain_ff;
   logic       smooth_en_ff;
   logic [6:0] sim_thresh_ff;
   logic       fade_en_ff;
   logic [6:0] fade_steps_ff;
   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   lcsf_pkg::job_type fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_level_ff <= 8'd255;
         sat_gain_ff <= 10'd358;
         smooth_en_ff <= 1'b0;
         sim_thresh_ff <= 7'd24;
         fade_en_ff <= 1'b1;
         fade_steps_ff <= 7'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            lcsf_pkg::CSR_LED_LEVEL:  led_level_ff <= csr_data[7:0];
            lcsf_pkg::CSR_SAT_GAIN:   sat_gain_ff <= csr_data;
            lcsf_pkg::CSR_SMOOTH_EN:  smooth_en_ff <= csr_data[0];
            lcsf_pkg::CSR_SIM_THRESH: sim_thresh_ff <= csr_data[6:0];
            lcsf_pkg::CSR_FADE_EN:    fade_en_ff <= csr_data[0];
            lcsf_pkg::CSR_FADE_STEPS: fade_steps_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   lcsf_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .red_in(req_red_in), .green_in(req_green_in), .blue_in(req_blue_in),
      .led_level(led_level_ff), .saturation_gain(sat_gain_ff),
      .smooth_enable(smooth_en_ff), .sim_thresh(sim_thresh_ff),
      .fade_enable(fade_en_ff), .fade_steps(fade_steps_ff),
      .max_steps(7'(MAX_FADE_STEPS)),
      .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
   );

   lcsf_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
   );

   lcsf_fade u_fade (
      .clock(clock), .reset(reset),
      .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .red_out(rsp_red_out), .green_out(rsp_green_out), .blue_out(rsp_blue_out),
      .changed(rsp_changed), .last_step(rsp_last_step)
   );

endmodule

[sv/lcsf_front.sv]
module lcsf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           red_in,
   input  logic [7:0]           green_in,
   input  logic [7:0]           blue_in,
   input  logic [7:0]           led_level,
   input  logic [9:0]           saturation_gain,
   input  logic                 smooth_enable,
   input  logic [6:0]           sim_thresh,
   input  logic                 fade_enable,
   input  logic [6:0]           fade_steps,
   input  logic [6:0]           max_steps,
   output logic                 job_valid,
   input  logic                 job_ready,
   output lcsf_pkg::job_type    job_data
);

   lcsf_pkg::adj_state_type state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [7:0]  chan_ff [3];
   logic [15:0] v_ff [3];
   logic [31:0] luma_acc_ff, luma_acc_in;
   logic signed [27:0] t_ff, t_in;
   logic [7:0]  col_ff [3];
   lcsf_pkg::color_type hist_ff [3];
   logic [2:0]  hval_ff;
   logic [15:0] luma;
   logic [7:0]  cur_chan;
   logic [15:0] cur_v;
   logic [15:0] scale_q;
   logic [15:0] luma_w;
   logic signed [17:0] vdiff;
   logic signed [27:0] prod_t;
   logic signed [27:0] t_clamp;
   logic [7:0]  rounded;
   lcsf_pkg::color_type new_col;
   logic [6:0]  th;
   logic        similar;
   logic [6:0]  nsteps;

   assign cur_chan = chan_ff[idx_ff];
   assign cur_v = v_ff[idx_ff];
   assign luma = luma_acc_ff[31:16];

   // c*level*256/255: divide by 255 with reciprocal estimate and a one-step fixup
   always_comb begin
      logic [15:0] cl;
      logic [23:0] p;
      logic [23:0] q;
      logic [23:0] r;
      cl = cur_chan * led_level;
      p = {cl, 8'd0};
      q = (p + (p >> 8) + 24'd1) >> 8;
      r = p - q * 24'd255;
      if (r[23]) q = q - 24'd1;
      else if (r >= 24'd255) q = q + 24'd1;
      scale_q = q[15:0];
   end

   always_comb begin
      unique case (idx_ff)
         2'd0: luma_w = lcsf_pkg::LumaWr;
         2'd1: luma_w = lcsf_pkg::LumaWg;
         default: luma_w = lcsf_pkg::LumaWb;
      endcase
   end

   assign vdiff = $signed({2'b00, cur_v}) - $signed({2'b00, luma});
   assign prod_t = $signed({4'd0, luma, 8'd0}) +
                   $signed(vdiff) * $signed({1'b0, saturation_gain});

   always_comb begin
      if (t_ff < 0) t_clamp = '0;
      else if (t_ff > 28'sd16711680) t_clamp = 28'sd16711680;
      else t_clamp = t_ff;
   end
   assign rounded = 8'((t_clamp + 28'sd32768) >>> 16);

   assign new_col = '{r: col_ff[0], g: col_ff[1], b: col_ff[2]};

   always_comb begin
      if (sim_thresh < 7'd4) th = 7'd4;
      else if (sim_thresh > 7'd64) th = 7'd64;
      else th = sim_thresh;
   end

   // hist_ff[1], hist_ff[2] are the two older entries; new_col is newest
   always_comb begin
      logic [7:0] m0;
      logic [7:0] m1;
      m0 = lcsf_pkg::abs_diff(hist_ff[1].r, hist_ff[2].r);
      if (lcsf_pkg::abs_diff(hist_ff[1].g, hist_ff[2].g) > m0)
         m0 = lcsf_pkg::abs_diff(hist_ff[1].g, hist_ff[2].g);
      if (lcsf_pkg::abs_diff(hist_ff[1].b, hist_ff[2].b) > m0)
         m0 = lcsf_pkg::abs_diff(hist_ff[1].b, hist_ff[2].b);
      m1 = lcsf_pkg::abs_diff(hist_ff[2].r, new_col.r);
      if (lcsf_pkg::abs_diff(hist_ff[2].g, new_col.g) > m1)
         m1 = lcsf_pkg::abs_diff(hist_ff[2].g, new_col.g);
      if (lcsf_pkg::abs_diff(hist_ff[2].b, new_col.b) > m1)
         m1 = lcsf_pkg::abs_diff(hist_ff[2].b, new_col.b);
      similar = !(smooth_enable && hval_ff[1] && hval_ff[2]) ||
                ((m0 <= {1'b0, th}) && (m1 <= {1'b0, th}));
   end

   always_comb begin
      if (!fade_enable || fade_steps == 7'd0) nsteps = 7'd1;
      else if (fade_steps > max_steps) nsteps = max_steps;
      else nsteps = fade_steps;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcsf_pkg::ADJ_IDLE:  if (req_valid) state_in = lcsf_pkg::ADJ_SCALE;
         lcsf_pkg::ADJ_SCALE: if (idx_ff == 2'd2) state_in = lcsf_pkg::ADJ_LUMA;
         lcsf_pkg::ADJ_LUMA:  if (idx_ff == 2'd2) state_in = lcsf_pkg::ADJ_BOOST;
         lcsf_pkg::ADJ_BOOST: state_in = lcsf_pkg::ADJ_ROUND;
         lcsf_pkg::ADJ_ROUND:
            if (idx_ff == 2'd2) state_in = lcsf_pkg::ADJ_PUSH;
            else state_in = lcsf_pkg::ADJ_BOOST;
         lcsf_pkg::ADJ_PUSH:
            if (!similar || job_ready) state_in = lcsf_pkg::ADJ_IDLE;
         default: state_in = lcsf_pkg::ADJ_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      luma_acc_in = luma_acc_ff;
      t_in = t_ff;
      unique case (state_ff)
         lcsf_pkg::ADJ_IDLE: idx_in = 2'd0;
         lcsf_pkg::ADJ_SCALE: begin
            idx_in = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            luma_acc_in = '0;
         end
         lcsf_pkg::ADJ_LUMA: begin
            idx_in = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            luma_acc_in = luma_acc_ff + cur_v * luma_w;
         end
         lcsf_pkg::ADJ_BOOST: t_in = prod_t;
         lcsf_pkg::ADJ_ROUND: idx_in = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == lcsf_pkg::ADJ_IDLE);
   assign job_valid = (state_ff == lcsf_pkg::ADJ_PUSH) && similar;
   assign job_data = '{color: new_col, steps: nsteps};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsf_pkg::ADJ_IDLE;
         hval_ff <= '0;
         for (int i = 0; i < 3; i++) hist_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == lcsf_pkg::ADJ_PUSH && state_in == lcsf_pkg::ADJ_IDLE) begin
            hist_ff[0] <= hist_ff[1];
            hist_ff[1] <= hist_ff[2];
            hist_ff[2] <= new_col;
            hval_ff <= {1'b1, hval_ff[2:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      luma_acc_ff <= luma_acc_in;
      t_ff <= t_in;
      if (req_valid && req_ready) begin
         chan_ff[0] <= red_in;
         chan_ff[1] <= green_in;
         chan_ff[2] <= blue_in;
      end
      if (state_ff == lcsf_pkg::ADJ_SCALE) v_ff[idx_ff] <= scale_q;
      if (state_ff == lcsf_pkg::ADJ_ROUND) col_ff[idx_ff] <= rounded;
   end

endmodule

[sv/lcsf_queue.sv]
module lcsf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  lcsf_pkg::job_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output lcsf_pkg::job_type rd_data
);

   lcsf_pkg::job_type mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data = mem_ff[rptr_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= ~wptr_ff;
         if (do_rd) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wptr_ff] <= wr_data;
   end

endmodule

[sv/lcsf_fade.sv]
module lcsf_fade (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  lcsf_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        red_out,
   output logic [7:0]        green_out,
   output logic [7:0]        blue_out,
   output logic              changed,
   output logic              last_step
);

   lcsf_pkg::fade_state_type state_ff, state_in;
   lcsf_pkg::color_type end_ff, tgt_ff, pub_ff, step_col_ff;
   logic        pub_val_ff;
   logic [6:0]  n_ff, s_ff;
   logic [1:0]  idx_ff;
   logic [3:0]  bit_ff;
   logic [14:0] num_ff, rem_ff, quo_ff;
   logic        neg_ff;
   logic        chg_ff, last_ff;
   logic [7:0]  e_cur, t_cur;
   logic signed [8:0] diff;
   logic signed [15:0] prod;
   logic signed [15:0] num_s;
   logic [14:0] rem_sh;
   logic signed [16:0] val;
   logic [7:0]  val_c;
   lcsf_pkg::color_type step_next;

   always_comb begin
      unique case (idx_ff)
         2'd0: begin e_cur = end_ff.r; t_cur = tgt_ff.r; end
         2'd1: begin e_cur = end_ff.g; t_cur = tgt_ff.g; end
         default: begin e_cur = end_ff.b; t_cur = tgt_ff.b; end
      endcase
   end

   // (t-e)*s + n/2 as sign and magnitude, restoring division over 15 bits
   assign diff = $signed({1'b0, t_cur}) - $signed({1'b0, e_cur});
   assign prod = diff * $signed({1'b0, s_ff}) + $signed({9'd0, n_ff[6:1]});
   assign num_s = prod;
   assign rem_sh = {rem_ff[13:0], num_ff[14]};
   assign val = $signed({9'd0, e_cur}) +
                (neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff}));
   always_comb begin
      if (val < 0) val_c = 8'd0;
      else if (val > 17'sd255) val_c = 8'd255;
      else val_c = val[7:0];
   end

   always_comb begin
      step_next = step_col_ff;
      unique case (idx_ff)
         2'd0: step_next.r = val_c;
         2'd1: step_next.g = val_c;
         default: step_next.b = val_c;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcsf_pkg::FD_IDLE: if (job_valid) state_in = lcsf_pkg::FD_MUL;
         lcsf_pkg::FD_MUL:  state_in = lcsf_pkg::FD_DIV;
         lcsf_pkg::FD_DIV:  if (bit_ff == 4'd14) state_in = lcsf_pkg::FD_FIN;
         lcsf_pkg::FD_FIN:
            if (idx_ff == 2'd2) state_in = lcsf_pkg::FD_OUT;
            else state_in = lcsf_pkg::FD_MUL;
         lcsf_pkg::FD_OUT:
            if (rsp_ready) state_in = last_ff ? lcsf_pkg::FD_IDLE : lcsf_pkg::FD_MUL;
         default: state_in = lcsf_pkg::FD_IDLE;
      endcase
   end

   assign job_ready = (state_ff == lcsf_pkg::FD_IDLE);
   assign rsp_valid = (state_ff == lcsf_pkg::FD_OUT);
   assign red_out = step_col_ff.r;
   assign green_out = step_col_ff.g;
   assign blue_out = step_col_ff.b;
   assign changed = chg_ff;
   assign last_step = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsf_pkg::FD_IDLE;
         end_ff <= '0;
         pub_ff <= '0;
         pub_val_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == lcsf_pkg::FD_FIN && idx_ff == 2'd2) begin
            if (!pub_val_ff || step_next != pub_ff) begin
               pub_ff <= step_next;
               pub_val_ff <= 1'b1;
            end
         end
         if (state_ff == lcsf_pkg::FD_OUT && rsp_ready && last_ff) end_ff <= tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         lcsf_pkg::FD_IDLE: begin
            tgt_ff <= job_data.color;
            n_ff <= job_data.steps;
            s_ff <= 7'd1;
            idx_ff <= 2'd0;
         end
         lcsf_pkg::FD_MUL: begin
            neg_ff <= num_s[15];
            num_ff <= num_s[15] ? 15'(-num_s) : num_s[14:0];
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= '0;
         end
         lcsf_pkg::FD_DIV: begin
            bit_ff <= bit_ff + 4'd1;
            num_ff <= {num_ff[13:0], 1'b0};
            if (rem_sh >= {8'd0, n_ff}) begin
               rem_ff <= rem_sh - {8'd0, n_ff};
               quo_ff <= {quo_ff[13:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[13:0], 1'b0};
            end
         end
         lcsf_pkg::FD_FIN: begin
            step_col_ff <= step_next;
            if (idx_ff == 2'd2) begin
               idx_ff <= 2'd0;
               chg_ff <= !pub_val_ff || step_next != pub_ff;
               last_ff <= (s_ff == n_ff);
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
         lcsf_pkg::FD_OUT: if (rsp_ready) s_ff <= s_ff + 7'd1;
         default: ;
      endcase
   end

endmodule

[sim/tb_led_color_smoother_fader.sv]
module tb_led_color_smoother_fader;

   typedef struct {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       changed;
      logic       last;
   } step_type;

   localparam int IdleWait = 400;
   localparam int StallLimit = 6000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_red_in;
   logic [7:0] req_green_in;
   logic [7:0] req_blue_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic       rsp_changed;
   logic       rsp_last_step;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [9:0] csr_data;

   led_color_smoother_fader u_top (.*);

   // mirror of the block's registers and state
   logic [7:0] led_level_q;
   logic [9:0] sat_gain_q;
   logic       smooth_en_q;
   logic [6:0] sim_thresh_q;
   logic       fade_en_q;
   logic [6:0] fade_steps_q;
   lcsf_pkg::color_type hist_color[3];
   logic       hist_valid[3];
   lcsf_pkg::color_type endpoint_q;
   lcsf_pkg::color_type published_q;
   logic       published_valid_q;

   lcsf_pkg::color_type pending_colors[$];
   step_type   expected_steps[$];
   int         errors;
   int         idle_cycles;
   bit         req_fire;
   int         req_gap;
   int         rsp_gap;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [7:0] boost(longint v, longint luma, logic [9:0] gain);
      longint t;
      t = luma * 256 + (v - luma) * longint'(gain);
      if (t < 0) t = 0;
      if (t > 255 * 65536) t = 255 * 65536;
      return 8'((t + 32768) >>> 16);
   endfunction

   function automatic int max_delta(lcsf_pkg::color_type a, lcsf_pkg::color_type b);
      int d[3];
      int m;
      d[0] = (a.r > b.r) ? a.r - b.r : b.r - a.r;
      d[1] = (a.g > b.g) ? a.g - b.g : b.g - a.g;
      d[2] = (a.b > b.b) ? a.b - b.b : b.b - a.b;
      m = d[0];
      if (d[1] > m) m = d[1];
      if (d[2] > m) m = d[2];
      return m;
   endfunction

   // scale, boost, shift history, and queue the fade run if accepted
   task automatic predict_fade(lcsf_pkg::color_type cin);
      longint    v[3];
      longint    luma;
      lcsf_pkg::color_type col;
      lcsf_pkg::color_type stepc;
      bit        ok;
      int        th;
      int        n;
      int        e[3];
      int        tg[3];
      int        x;
      step_type  st;
      v[0] = (longint'(cin.r) * led_level_q * 256) / 255;
      v[1] = (longint'(cin.g) * led_level_q * 256) / 255;
      v[2] = (longint'(cin.b) * led_level_q * 256) / 255;
      luma = (longint'(lcsf_pkg::LumaWr) * v[0] + longint'(lcsf_pkg::LumaWg) * v[1]
              + longint'(lcsf_pkg::LumaWb) * v[2]) / 65536;
      col.r = boost(v[0], luma, sat_gain_q);
      col.g = boost(v[1], luma, sat_gain_q);
      col.b = boost(v[2], luma, sat_gain_q);
      hist_color[0] = hist_color[1];
      hist_valid[0] = hist_valid[1];
      hist_color[1] = hist_color[2];
      hist_valid[1] = hist_valid[2];
      hist_color[2] = col;
      hist_valid[2] = 1'b1;
      ok = 1'b1;
      if (smooth_en_q && hist_valid[0] && hist_valid[1]) begin
         th = sim_thresh_q;
         if (th < 4) th = 4;
         if (th > 64) th = 64;
         ok = max_delta(hist_color[0], hist_color[1]) <= th
              && max_delta(hist_color[1], hist_color[2]) <= th;
      end
      if (!ok) return;
      n = 1;
      if (fade_en_q) begin
         n = fade_steps_q;
         if (n < 1) n = 1;
         if (n > 64) n = 64;
      end
      e[0] = endpoint_q.r;
      e[1] = endpoint_q.g;
      e[2] = endpoint_q.b;
      tg[0] = col.r;
      tg[1] = col.g;
      tg[2] = col.b;
      for (int s = 1; s <= n; s++) begin
         for (int i = 0; i < 3; i++) begin
            x = e[i] + ((tg[i] - e[i]) * s + n / 2) / n;
            if (x < 0) x = 0;
            if (x > 255) x = 255;
            if (i == 0) stepc.r = 8'(x);
            else if (i == 1) stepc.g = 8'(x);
            else stepc.b = 8'(x);
         end
         st.r = stepc.r;
         st.g = stepc.g;
         st.b = stepc.b;
         st.changed = !published_valid_q || stepc != published_q;
         st.last = (s == n);
         if (st.changed) begin
            published_q = stepc;
            published_valid_q = 1'b1;
         end
         expected_steps.push_back(st);
      end
      endpoint_q = col;
   endtask

   // sample both channels, predict and check
   always @(posedge clock) begin
      step_type exp_step;
      req_fire = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            idle_cycles = 0;
            predict_fade('{r: req_red_in, g: req_green_in, b: req_blue_in});
         end
         if (csr_valid && csr_ready) idle_cycles = 0;
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_steps.size() == 0) begin
               errors++;
               $display("%0t: unexpected step %h %h %h changed=%b last=%b", $time,
                        rsp_red_out, rsp_green_out, rsp_blue_out, rsp_changed,
                        rsp_last_step);
            end else begin
               exp_step = expected_steps.pop_front();
               if (rsp_red_out !== exp_step.r || rsp_green_out !== exp_step.g
                   || rsp_blue_out !== exp_step.b || rsp_changed !== exp_step.changed
                   || rsp_last_step !== exp_step.last) begin
                  errors++;
                  $display("%0t: expected %h %h %h changed=%b last=%b, %s",
                           $time, exp_step.r, exp_step.g, exp_step.b, exp_step.changed,
                           exp_step.last,
                           $sformatf("got %h %h %h changed=%b last=%b",
                                     rsp_red_out, rsp_green_out, rsp_blue_out,
                                     rsp_changed, rsp_last_step));
               end
            end
         end
         if (idle_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // drive colors with random gaps; hold until the transfer
   always @(negedge clock) begin
      logic      next_valid;
      lcsf_pkg::color_type item;
      next_valid = req_valid;
      if (!reset && (req_fire || !req_valid)) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_colors.size() > 0) begin
            item = pending_colors.pop_front();
            next_valid = 1'b1;
            req_red_in <= item.r;
            req_green_in <= item.g;
            req_blue_in <= item.b;
            req_gap = pick_gap();
         end
      end
      req_valid <= next_valid;
   end

   // stall the result side at random
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [9:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         lcsf_pkg::CSR_LED_LEVEL:  led_level_q = data[7:0];
         lcsf_pkg::CSR_SAT_GAIN:   sat_gain_q = data;
         lcsf_pkg::CSR_SMOOTH_EN:  smooth_en_q = data[0];
         lcsf_pkg::CSR_SIM_THRESH: sim_thresh_q = data[6:0];
         lcsf_pkg::CSR_FADE_EN:    fade_en_q = data[0];
         lcsf_pkg::CSR_FADE_STEPS: fade_steps_q = data[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(int lvl, int gain, int sen, int sdelta, int fen, int steps);
      write_csr(lcsf_pkg::CSR_LED_LEVEL, 10'(lvl));
      write_csr(lcsf_pkg::CSR_SAT_GAIN, 10'(gain));
      write_csr(lcsf_pkg::CSR_SMOOTH_EN, 10'(sen));
      write_csr(lcsf_pkg::CSR_SIM_THRESH, 10'(sdelta));
      write_csr(lcsf_pkg::CSR_FADE_EN, 10'(fen));
      write_csr(lcsf_pkg::CSR_FADE_STEPS, 10'(steps));
   endtask

   // check at the rising edge, where the driver's outputs have settled
   task automatic drain();
      while (pending_colors.size() > 0 || req_valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (IdleWait) @(negedge clock);
   endtask

   function automatic lcsf_pkg::color_type rand_color();
      return lcsf_pkg::color_type'(24'($urandom_range(0, 24'hFFFFFF)));
   endfunction

   function automatic logic [7:0] jitter(logic [7:0] c);
      int x;
      x = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return 8'(x);
   endfunction

   // mostly runs of similar colors, with jumps and noise in between
   task automatic add_random(int count);
      lcsf_pkg::color_type base;
      lcsf_pkg::color_type c;
      base = rand_color();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) base = rand_color();
         if ($urandom_range(0, 9) == 0) begin
            c = rand_color();
         end else begin
            c.r = jitter(base.r);
            c.g = jitter(base.g);
            c.b = jitter(base.b);
         end
         pending_colors.push_back(c);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      idle_cycles = 0;
      req_gap = 0;
      rsp_gap = 0;
      led_level_q = 8'd255;
      sat_gain_q = 10'd358;
      smooth_en_q = 1'b0;
      sim_thresh_q = 7'd24;
      fade_en_q = 1'b1;
      fade_steps_q = 7'd10;
      for (int i = 0; i < 3; i++) begin
         hist_color[i] = '0;
         hist_valid[i] = 1'b0;
      end
      endpoint_q = '0;
      published_q = '0;
      published_valid_q = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: extremes, primaries, repeats that publish nothing new
      pending_colors.push_back('{r: 8'd0, g: 8'd0, b: 8'd0});
      pending_colors.push_back('{r: 8'd255, g: 8'd255, b: 8'd255});
      pending_colors.push_back('{r: 8'd255, g: 8'd255, b: 8'd255});
      pending_colors.push_back('{r: 8'd255, g: 8'd0, b: 8'd0});
      pending_colors.push_back('{r: 8'd0, g: 8'd255, b: 8'd0});
      pending_colors.push_back('{r: 8'd0, g: 8'd0, b: 8'd255});
      pending_colors.push_back('{r: 8'd1, g: 8'd128, b: 8'd254});
      drain();

      // fade off, zero level and gain, zero step count
      set_regs(0, 0, 0, 24, 0, 0);
      pending_colors.push_back('{r: 8'd200, g: 8'd100, b: 8'd50});
      pending_colors.push_back('{r: 8'd255, g: 8'd255, b: 8'd255});
      drain();

      // max gain, step count clamped up, delta clamped up, smoothing with a jump
      set_regs(255, 1023, 1, 0, 1, 0);
      pending_colors.push_back('{r: 8'd40, g: 8'd40, b: 8'd40});
      pending_colors.push_back('{r: 8'd41, g: 8'd40, b: 8'd39});
      pending_colors.push_back('{r: 8'd40, g: 8'd41, b: 8'd40});
      pending_colors.push_back('{r: 8'd250, g: 8'd10, b: 8'd10});
      pending_colors.push_back('{r: 8'd40, g: 8'd40, b: 8'd41});
      drain();

      // oversized step count and delta, unknown indexes, over-wide data
      set_regs(1023, 256, 1, 127, 1, 127);
      write_csr(3'd6, 10'h3FF);
      write_csr(3'd7, 10'h155);
      write_csr(lcsf_pkg::CSR_FADE_STEPS, 10'h3FF);
      pending_colors.push_back('{r: 8'd10, g: 8'd200, b: 8'd90});
      pending_colors.push_back('{r: 8'd12, g: 8'd198, b: 8'd91});
      pending_colors.push_back('{r: 8'd255, g: 8'd0, b: 8'd255});
      drain();

      for (int p = 0; p < 7; p++) begin
         set_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 127), $urandom_range(0, 3) != 0,
                  (p == 3) ? 64 : $urandom_range(1, 8));
         add_random((p == 3) ? 10 : 65);
         drain();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/lcsf_pkg.sv
sv/lcsf_front.sv
sv/lcsf_queue.sv
sv/lcsf_fade.sv
sv/led_color_smoother_fader.sv
sim/tb_led_color_smoother_fader.sv
